// File: rtl/core/xps_pkg.sv
// Shared types and constants for the pointer reference scanner.
`default_nettype none

package xps_pkg;

   localparam int ABS_BYTES   = 8;
   localparam int WIN_DEPTH   = ABS_BYTES - 1;
   localparam int WIN_BITS    = 8 * WIN_DEPTH;
   localparam int WORD_BITS   = 8 * ABS_BYTES;
   localparam int FILL_W      = 3;
   localparam int MAX_RESULTS = 5;
   localparam int Q_DEPTH     = 4;
   localparam int CSR_INDEX_W = 2;

   // Offset of the position decided by a full window, and the largest flush start offset.
   localparam logic [FILL_W-1:0] MAIN_K      = FILL_W'(WIN_DEPTH);
   localparam logic [FILL_W-1:0] FLUSH_K_MAX = FILL_W'(WIN_DEPTH - 1);

   typedef enum logic [CSR_INDEX_W-1:0] {
      CSR_TARGET = 2'd0,
      CSR_ABS_EN = 2'd1,
      CSR_REL_EN = 2'd2,
      CSR_END    = 2'd3
   } csr_index_type;

   typedef struct packed {
      logic [63:0] target;
      logic        abs_en;
      logic        rel_en;
      logic [63:0] end_addr;
   } cfg_type;

   // One classified request: address, the eight bytes ending at it, and what to check.
   typedef struct packed {
      logic [63:0]           addr;
      logic [WORD_BITS-1:0]  word;
      logic                  main;
      logic                  last;
      logic [FILL_W-1:0]     kmax;
   } job_type;

   typedef struct packed {
      logic chk_abs;
      logic chk_rel;
      logic is_close;
      logic first;
   } step_flags_type;

endpackage

`default_nettype wire

// File: rtl/core/xps_front.sv
// Front end: byte window, fill count and classification of each request.
`default_nettype none

module xps_front (
   input  wire logic                    clock,
   input  wire logic                    reset,
   input  wire logic                    req_valid,
   output logic                         req_ready,
   input  wire logic [7:0]              req_data_byte,
   input  wire logic [63:0]             req_byte_address,
   input  wire logic                    req_last_byte,
   input  wire logic                    q_full,
   output logic                         q_push,
   output xps_pkg::job_type             q_job
);

   logic [xps_pkg::WIN_BITS-1:0] win_ff, win_in;
   logic [xps_pkg::FILL_W-1:0]   fill_ff, fill_in;
   logic                         accept;
   logic                         main;

   always_comb begin
      req_ready  = !q_full;
      accept     = req_valid && req_ready;
      main       = (fill_ff == xps_pkg::MAIN_K);
      q_job.addr = req_byte_address;
      q_job.word = {req_data_byte, win_ff};
      q_job.main = main;
      q_job.last = req_last_byte;
      q_job.kmax = main ? xps_pkg::FLUSH_K_MAX : fill_ff;
      // Requests that decide nothing never enter the queue.
      q_push     = accept && (main || req_last_byte);

      win_in  = win_ff;
      fill_in = fill_ff;
      if (accept) begin
         if (req_last_byte) begin
            win_in  = '0;
            fill_in = '0;
         end else begin
            win_in = {req_data_byte, win_ff[xps_pkg::WIN_BITS-1:8]};
            if (!main) begin
               fill_in = fill_ff + 1'b1;
            end
         end
      end
   end

   always_ff @(posedge clock) begin
      if (reset) begin
         fill_ff <= '0;
      end else begin
         fill_ff <= fill_in;
      end
   end

   always_ff @(posedge clock) begin
      win_ff <= win_in;
   end

endmodule

`default_nettype wire

// File: rtl/core/xps_queue.sv
// Short job queue between the front end and the evaluation back end.
`default_nettype none

module xps_queue (
   input  wire logic             clock,
   input  wire logic             reset,
   input  wire logic             push,
   input  wire xps_pkg::job_type push_job,
   output logic                  full,
   input  wire logic             pop,
   output logic                  empty,
   output xps_pkg::job_type      head
);

   localparam int IDX_W = $clog2(xps_pkg::Q_DEPTH);
   localparam int CNT_W = $clog2(xps_pkg::Q_DEPTH + 1);
   localparam logic [IDX_W-1:0] LAST_IDX = IDX_W'(xps_pkg::Q_DEPTH - 1);

   xps_pkg::job_type mem_ff [xps_pkg::Q_DEPTH];
   logic [IDX_W-1:0] wr_ptr_ff, wr_ptr_in;
   logic [IDX_W-1:0] rd_ptr_ff, rd_ptr_in;
   logic [CNT_W-1:0] count_ff, count_in;
   logic             do_push, do_pop;

   always_comb begin
      full    = (count_ff == CNT_W'(xps_pkg::Q_DEPTH));
      empty   = (count_ff == '0);
      head    = mem_ff[rd_ptr_ff];
      do_push = push && !full;
      do_pop  = pop && !empty;

      wr_ptr_in = wr_ptr_ff;
      rd_ptr_in = rd_ptr_ff;
      count_in  = count_ff;
      if (do_push) begin
         wr_ptr_in = (wr_ptr_ff == LAST_IDX) ? '0 : wr_ptr_ff + 1'b1;
      end
      if (do_pop) begin
         rd_ptr_in = (rd_ptr_ff == LAST_IDX) ? '0 : rd_ptr_ff + 1'b1;
      end
      if (do_push && !do_pop) begin
         count_in = count_ff + 1'b1;
      end else if (do_pop && !do_push) begin
         count_in = count_ff - 1'b1;
      end
   end

   always_ff @(posedge clock) begin
      if (reset) begin
         wr_ptr_ff <= '0;
         rd_ptr_ff <= '0;
         count_ff  <= '0;
      end else begin
         wr_ptr_ff <= wr_ptr_in;
         rd_ptr_ff <= rd_ptr_in;
         count_ff  <= count_in;
      end
   end

   always_ff @(posedge clock) begin
      if (do_push) begin
         mem_ff[wr_ptr_ff] <= push_job;
      end
   end

endmodule

`default_nettype wire

// File: rtl/core/xps_back.sv
// Back end: steps through the positions of each job and evaluates the match rules.
`default_nettype none

module xps_back #(
   parameter int REL_BYTES = 4
) (
   input  wire logic             clock,
   input  wire logic             reset,
   input  wire xps_pkg::cfg_type cfg,
   input  wire logic             q_empty,
   input  wire xps_pkg::job_type q_head,
   output logic                  q_pop,
   output logic                  rsp_valid,
   input  wire logic             rsp_ready,
   output logic [63:0]           rsp_hit_address,
   output logic                  rsp_absolute_hit,
   output logic                  rsp_relative_hit,
   output logic                  rsp_last_result
);

   localparam int REL_W = 8 * REL_BYTES;
   localparam int KW    = xps_pkg::FILL_W;
   localparam logic [KW-1:0] REL_K_MIN = KW'(REL_BYTES - 1);
   localparam logic [63:0]   REL_NEED  = 64'(REL_BYTES);
   localparam logic [63:0]   ABS_NEED  = 64'(xps_pkg::ABS_BYTES);
   localparam logic [63:0]   REL_LIMIT = (64'd1 << (REL_W - 1)) - 64'd1;
   localparam logic [KW-1:0] HIT_CAP   = KW'(xps_pkg::MAX_RESULTS - 1);

   logic en;

   // ---------------- sequencer ----------------
   logic             act_ff, act_in;
   xps_pkg::job_type job_ff, job_in;
   logic [KW-1:0]    k_ff, k_in;
   logic             cls_ff, cls_in;
   logic             first_ff, first_in;
   logic             nxt_none, nxt_cls, ini_cls, load;
   logic [KW-1:0]    nxt_k, ini_k;

   always_comb begin
      en = !rsp_valid || rsp_ready;

      nxt_none = 1'b0;
      nxt_k    = k_ff;
      nxt_cls  = 1'b0;
      if (cls_ff) begin
         nxt_none = 1'b1;
      end else if (k_ff == xps_pkg::MAIN_K) begin
         if (!job_ff.last) begin
            nxt_none = 1'b1;
         end else if (job_ff.kmax >= REL_K_MIN) begin
            nxt_k = job_ff.kmax;
         end else begin
            nxt_cls = 1'b1;
         end
      end else if (k_ff > REL_K_MIN) begin
         nxt_k = k_ff - 1'b1;
      end else begin
         nxt_cls = 1'b1;
      end

      // A queued job is either a full-window byte or a last byte.
      ini_k   = '0;
      ini_cls = 1'b0;
      if (q_head.main) begin
         ini_k = xps_pkg::MAIN_K;
      end else if (q_head.kmax >= REL_K_MIN) begin
         ini_k = q_head.kmax;
      end else begin
         ini_cls = 1'b1;
      end

      load  = en && !q_empty && (!act_ff || nxt_none);
      q_pop = load;

      act_in   = act_ff;
      job_in   = job_ff;
      k_in     = k_ff;
      cls_in   = cls_ff;
      first_in = first_ff;
      if (load) begin
         act_in   = 1'b1;
         job_in   = q_head;
         k_in     = ini_k;
         cls_in   = ini_cls;
         first_in = 1'b1;
      end else if (en && act_ff) begin
         if (nxt_none) begin
            act_in = 1'b0;
         end else begin
            k_in     = nxt_k;
            cls_in   = nxt_cls;
            first_in = 1'b0;
         end
      end
   end

   always_ff @(posedge clock) begin
      if (reset) begin
         act_ff <= 1'b0;
      end else begin
         act_ff <= act_in;
      end
   end

   always_ff @(posedge clock) begin
      job_ff   <= job_in;
      k_ff     <= k_in;
      cls_ff   <= cls_in;
      first_ff <= first_in;
   end

   // ---------------- stage 1: position and word select ----------------
   logic [KW-1:0]           k_eff;
   logic signed [KW+1:0]    delta;
   logic [63:0]             p_s1, q_s1;
   logic [REL_W-1:0]        relw_s1;
   xps_pkg::step_flags_type flags_s1;

   logic                    s1_vld_ff;
   logic [63:0]             s1_p_ff, s1_q_ff;
   logic [63:0]             s1_absw_ff;
   logic [REL_W-1:0]        s1_relw_ff;
   xps_pkg::step_flags_type s1_flags_ff;

   always_comb begin
      // The closing record reports the last byte's own address.
      k_eff   = cls_ff ? '0 : k_ff;
      delta   = $signed((KW+2)'(REL_BYTES)) - $signed({2'b00, k_eff});
      p_s1    = job_ff.addr - 64'(k_eff);
      q_s1    = job_ff.addr + {{(64-KW-2){delta[KW+1]}}, delta};
      relw_s1 = REL_W'(job_ff.word >> {3'(xps_pkg::MAIN_K - k_ff), 3'b000});
      flags_s1.chk_abs  = !cls_ff && (k_ff == xps_pkg::MAIN_K);
      flags_s1.chk_rel  = !cls_ff;
      flags_s1.is_close = cls_ff;
      flags_s1.first    = first_ff;
   end

   always_ff @(posedge clock) begin
      if (reset) begin
         s1_vld_ff <= 1'b0;
      end else if (en) begin
         s1_vld_ff <= act_ff;
      end
   end

   always_ff @(posedge clock) begin
      if (en) begin
         s1_p_ff     <= p_s1;
         s1_q_ff     <= q_s1;
         s1_absw_ff  <= job_ff.word;
         s1_relw_ff  <= relw_s1;
         s1_flags_ff <= flags_s1;
      end
   end

   // ---------------- stage 2: differences ----------------
   logic                    s2_vld_ff;
   logic [63:0]             s2_p_ff, s2_e_ff, s2_dist_ff, s2_space_ff;
   logic                    s2_abs_eq_ff;
   logic [REL_W-1:0]        s2_relw_ff;
   xps_pkg::step_flags_type s2_flags_ff;

   always_ff @(posedge clock) begin
      if (reset) begin
         s2_vld_ff <= 1'b0;
      end else if (en) begin
         s2_vld_ff <= s1_vld_ff;
      end
   end

   always_ff @(posedge clock) begin
      if (en) begin
         s2_p_ff      <= s1_p_ff;
         s2_e_ff      <= cfg.target - s1_q_ff;
         s2_dist_ff   <= (cfg.target > s1_p_ff) ? cfg.target - s1_p_ff
                                                : s1_p_ff - cfg.target;
         s2_space_ff  <= cfg.end_addr - s1_p_ff;
         s2_abs_eq_ff <= (s1_absw_ff == cfg.target);
         s2_relw_ff   <= s1_relw_ff;
         s2_flags_ff  <= s1_flags_ff;
      end
   end

   // ---------------- stage 3: decision and output register ----------------
   logic          unbounded, abs_space, rel_space, dist_ok, disp_ok;
   logic          abs_hit, rel_hit, emit;
   logic [KW-1:0] n_ff, n_cur;

   logic          rsp_valid_ff;
   logic [63:0]   rsp_addr_ff;
   logic          rsp_abs_ff, rsp_rel_ff, rsp_last_ff;

   always_comb begin
      unbounded = (cfg.end_addr == '0);
      abs_space = unbounded || (s2_space_ff > ABS_NEED);
      rel_space = unbounded || (s2_space_ff > REL_NEED);
      dist_ok   = (s2_dist_ff < REL_LIMIT);
      disp_ok   = (s2_e_ff == {{(64-REL_W){s2_relw_ff[REL_W-1]}}, s2_relw_ff});
      abs_hit   = s2_flags_ff.chk_abs && cfg.abs_en && abs_space && s2_abs_eq_ff;
      rel_hit   = s2_flags_ff.chk_rel && cfg.rel_en && rel_space && dist_ok && disp_ok;
      // Hits per request are capped so the closing record always fits.
      n_cur     = s2_flags_ff.first ? '0 : n_ff;
      emit      = (abs_hit || rel_hit) && (n_cur < HIT_CAP);
   end

   always_ff @(posedge clock) begin
      if (reset) begin
         n_ff         <= '0;
         rsp_valid_ff <= 1'b0;
      end else if (en) begin
         if (s2_vld_ff) begin
            n_ff <= n_cur + KW'(emit);
         end
         rsp_valid_ff <= s2_vld_ff && (s2_flags_ff.is_close || emit);
      end
   end

   always_ff @(posedge clock) begin
      if (en) begin
         rsp_addr_ff <= s2_p_ff;
         rsp_abs_ff  <= abs_hit;
         rsp_rel_ff  <= rel_hit;
         rsp_last_ff <= s2_flags_ff.is_close;
      end
   end

   assign rsp_valid        = rsp_valid_ff;
   assign rsp_hit_address  = rsp_addr_ff;
   assign rsp_absolute_hit = rsp_abs_ff;
   assign rsp_relative_hit = rsp_rel_ff;
   assign rsp_last_result  = rsp_last_ff;

`ifndef SYNTH
   a_close_no_hit: assert property (@(posedge clock) disable iff (reset)
      rsp_valid_ff && rsp_last_ff |-> !rsp_abs_ff && !rsp_rel_ff)
      else $error("closing record carries a hit flag");

   a_hit_cap: assert property (@(posedge clock) disable iff (reset)
      n_ff <= HIT_CAP)
      else $error("per-request hit count over cap");

   a_flush_step: assert property (@(posedge clock) disable iff (reset)
      act_ff && !cls_ff && (k_ff != xps_pkg::MAIN_K)
      |-> job_ff.last && (k_ff <= job_ff.kmax) && (k_ff >= REL_K_MIN))
      else $error("flush step outside a last request");

   a_pop_nonempty: assert property (@(posedge clock) disable iff (reset)
      q_pop |-> !q_empty && en)
      else $error("job popped from empty queue or while stalled");
`endif

endmodule

`default_nettype wire

// File: rtl/core/xref_pointer_scan_core.sv
// Top level of the pointer reference scanner: config registers and block wiring.
//
// Usage:
//   Memory bytes enter on the req_ channel (valid/ready), one per request, at
//   ascending consecutive addresses; req_last_byte marks the end of a scan.
//   Records leave on the rsp_ channel (valid/ready) in ascending hit_address
//   order; each scan ends with a closing record (rsp_last_result = 1).
//   Write registers via csr_we/csr_index/csr_wdata only while idle (user's duty).
// Timing:
//   A request is taken every cycle while the job queue has room. Jobs pass
//   the queue, the sequencer and stages 1 to 3. A full-window byte takes one
//   position; a last byte takes the main check (full window only), the relative
//   flush positions and the closing record. Unless the receiver stalls, the
//   back end evaluates one position per cycle; its three stages hold the
//   position subtract, the target/end differences and the final compares.
// Reset:
//   Synchronous reset empties the window, the queue and the pipeline and
//   restores the register defaults (both match kinds on, target and end 0).
// Stall:
//   A stalled receiver freezes the back end; the queue fills and then
//   req_ready drops until records drain.
`default_nettype none

module xref_pointer_scan_core #(
   parameter int REL_BYTES = 4
) (
   input  wire logic                            clock,
   input  wire logic                            reset,
   input  wire logic                            req_valid,
   output logic                                 req_ready,
   input  wire logic [7:0]                      req_data_byte,
   input  wire logic [63:0]                     req_byte_address,
   input  wire logic                            req_last_byte,
   output logic                                 rsp_valid,
   input  wire logic                            rsp_ready,
   output logic [63:0]                          rsp_hit_address,
   output logic                                 rsp_absolute_hit,
   output logic                                 rsp_relative_hit,
   output logic                                 rsp_last_result,
   input  wire logic                            csr_we,
   input  wire logic [xps_pkg::CSR_INDEX_W-1:0] csr_index,
   input  wire logic [63:0]                     csr_wdata
);

   xps_pkg::cfg_type cfg_ff, cfg_in;
   xps_pkg::job_type push_job, head_job;
   logic             q_push, q_pop, q_full, q_empty;

   always_comb begin
      cfg_in = cfg_ff;
      if (csr_we) begin
         case (xps_pkg::csr_index_type'(csr_index))
            xps_pkg::CSR_TARGET: cfg_in.target   = csr_wdata;
            xps_pkg::CSR_ABS_EN: cfg_in.abs_en   = csr_wdata[0];
            xps_pkg::CSR_REL_EN: cfg_in.rel_en   = csr_wdata[0];
            xps_pkg::CSR_END:    cfg_in.end_addr = csr_wdata;
            default:             cfg_in = cfg_ff;
         endcase
      end
   end

   always_ff @(posedge clock) begin
      if (reset) begin
         cfg_ff.target   <= '0;
         cfg_ff.abs_en   <= 1'b1;
         cfg_ff.rel_en   <= 1'b1;
         cfg_ff.end_addr <= '0;
      end else begin
         cfg_ff <= cfg_in;
      end
   end

   xps_front u_front (
      .clock            (clock),
      .reset            (reset),
      .req_valid        (req_valid),
      .req_ready        (req_ready),
      .req_data_byte    (req_data_byte),
      .req_byte_address (req_byte_address),
      .req_last_byte    (req_last_byte),
      .q_full           (q_full),
      .q_push           (q_push),
      .q_job            (push_job)
   );

   xps_queue u_queue (
      .clock    (clock),
      .reset    (reset),
      .push     (q_push),
      .push_job (push_job),
      .full     (q_full),
      .pop      (q_pop),
      .empty    (q_empty),
      .head     (head_job)
   );

   xps_back #(
      .REL_BYTES (REL_BYTES)
   ) u_back (
      .clock            (clock),
      .reset            (reset),
      .cfg              (cfg_ff),
      .q_empty          (q_empty),
      .q_head           (head_job),
      .q_pop            (q_pop),
      .rsp_valid        (rsp_valid),
      .rsp_ready        (rsp_ready),
      .rsp_hit_address  (rsp_hit_address),
      .rsp_absolute_hit (rsp_absolute_hit),
      .rsp_relative_hit (rsp_relative_hit),
      .rsp_last_result  (rsp_last_result)
   );

endmodule

`default_nettype wire
